>>> sv/rsnh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ray/segment nearest-hit block.
// Holds the word structs, the sequencer enums and the derived widths; depends on nothing.
package rsnh_pkg;

  // Coordinate width; every other width but the configuration index follows from it.
  localparam int CW   = 24;
  localparam int EW   = CW + 1;          // start minus origin
  localparam int MW   = CW + 2;          // multiplier operand, signed
  localparam int MPW  = 2 * MW;          // multiplier product
  localparam int XW   = 2 * CW + 2;      // cross product, signed
  localparam int MAGW = 2 * CW + 1;      // cross product magnitude
  localparam int LOW  = CW + 1;          // low slice of the numerator magnitude
  localparam int HIW  = MAGW - LOW;      // high slice of the numerator magnitude
  localparam int PW   = 3 * CW + 2;      // dividend width
  localparam int CNTW = $clog2(CW + 2);  // step counter
  localparam int IDXW = 3;               // configuration index

  // Last step of the cross product phase and of the dividend build phase.
  localparam logic [CNTW-1:0] CROSS_LAST = CNTW'(6);
  localparam logic [CNTW-1:0] PROD_LAST  = CNTW'(2);

  // Clamp limits of a hit coordinate, in the width of the offset sum.
  localparam logic signed [CW+2:0] COORD_MAX = {{4{1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] COORD_MIN = {{4{1'b1}}, {(CW-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [IDXW-1:0] REG_ORIGIN_X   = IDXW'(0);
  localparam logic [IDXW-1:0] REG_ORIGIN_Y   = IDXW'(1);
  localparam logic [IDXW-1:0] REG_DIR_X      = IDXW'(2);
  localparam logic [IDXW-1:0] REG_DIR_Y      = IDXW'(3);
  localparam logic [IDXW-1:0] REG_DIR_LENGTH = IDXW'(4);

  typedef struct packed {
    logic                 new_ray;
    logic signed [CW-1:0] wall_start_x;
    logic signed [CW-1:0] wall_start_y;
    logic signed [CW-1:0] wall_vec_x;
    logic signed [CW-1:0] wall_vec_y;
  } wall_t;

  typedef struct packed {
    logic                 updated;
    logic                 hit_valid;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic        [CW-1:0] hit_distance;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_ORIENT,
    ST_TEST,
    ST_PROD,
    ST_SAT,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

  // Which quotient the divider is working on.
  typedef enum logic [1:0] {
    PH_DIST,
    PH_X,
    PH_Y
  } phase_t;

endpackage

>>> sv/ray_segment_nearest_hit.sv
`timescale 1ns / 1ps
// Top level of the ray/segment nearest-hit block: sequencer, shared multiplier and divider.
// Depends on rsnh_pkg for widths, word structs and state codes.

// Each wall word is intersected with the configured ray and the nearest hit so far is kept;
// one result word leaves per wall. A wall that misses ends after the hit test, one that hits
// but is not nearer after the distance quotient, and a new nearest hit after both coordinate
// quotients; a saturating quotient skips its division. The work falls to the single 26x26
// multiplier, which forms the six cross product terms and the two halves of each dividend,
// and to the restoring divider, which yields one quotient bit per cycle for the distance and
// for each hit coordinate. Wall words are not taken while a wall is in work; one finished
// result may wait in the output register while the next wall is accepted.
module ray_segment_nearest_hit import rsnh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            wall_valid,
  output logic            wall_stall,
  input  wall_t           wall,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [CW-1:0]   cfg_data
);

  // Configuration registers.
  logic signed [CW-1:0] origin_x, origin_y, dir_x, dir_y;
  logic        [CW-1:0] dir_length;

  // Stored nearest hit.
  logic                 have_hit;
  logic        [CW-1:0] nearest_distance;
  logic signed [CW-1:0] nearest_x, nearest_y;

  // Sequencer.
  state_t          state, state_next;
  phase_t          phase;
  logic [CNTW-1:0] cnt;

  // Working registers of one wall.
  logic signed [EW-1:0]   e_x, e_y;
  logic signed [CW-1:0]   w_x, w_y;
  logic signed [MPW-1:0]  prod, first;
  logic signed [XW-1:0]   n1, n2, den;
  logic        [MAGW-1:0] n1mag, denmag;
  logic        [PW-1:0]   acc;
  logic        [MAGW-1:0] rem;
  logic        [CW:0]     qr;
  logic                   sat;
  logic                   updated;

  // Combinational helpers.
  logic signed [MW-1:0]   mul_a, mul_b;
  logic        [CW-1:0]   dir_x_mag, dir_y_mag, factor;
  logic                   hit_ok, out_free, nearer, sat_now;
  logic        [PW-1:0]   rem_init;
  logic        [CW:0]     qr_init;
  logic        [MAGW:0]   r2, r2_diff;
  logic                   r2_ge;
  logic        [CNTW-1:0] div_last;
  logic        [CW-1:0]   dist_val;
  logic        [CW+1:0]   offset;
  logic signed [CW+2:0]   coord_base, coord_sum;
  logic signed [CW-1:0]   coord_val;
  logic                   coord_neg;

  assign cfg_ready = 1'b1;
  assign out_free  = !result_valid || !result_stall;

  assign dir_x_mag = dir_x[CW-1] ? CW'(-dir_x) : CW'(dir_x);
  assign dir_y_mag = dir_y[CW-1] ? CW'(-dir_y) : CW'(dir_y);

  // Hit test on the oriented cross products: not parallel, ahead of the origin, inside the wall.
  assign hit_ok = (den != '0) && !n1[XW-1] && !n2[XW-1] && (n2 <= den);

  // Dividend factor for the current quotient.
  always_comb begin
    case (phase)
      PH_DIST: factor = dir_length;
      PH_X:    factor = dir_x_mag;
      PH_Y:    factor = dir_y_mag;
      default: factor = dir_length;
    endcase
  end

  // Saturation check and divider start values; the distance quotient has one bit fewer.
  always_comb begin
    if (phase == PH_DIST) begin
      rem_init = acc >> CW;
      qr_init  = {acc[CW-1:0], 1'b0};
      div_last = CNTW'(CW - 1);
    end else begin
      rem_init = acc >> (CW + 1);
      qr_init  = acc[CW:0];
      div_last = CNTW'(CW);
    end
    sat_now = rem_init >= PW'(denmag);
  end

  // One restoring division step.
  assign r2      = {rem, qr[CW]};
  assign r2_ge   = r2 >= {1'b0, denmag};
  assign r2_diff = r2 - {1'b0, denmag};

  // Finished distance and its comparison with the stored one.
  assign dist_val = sat ? '1 : qr[CW-1:0];
  assign nearer   = !have_hit || (dist_val < nearest_distance);

  // Finished hit coordinate: origin plus or minus the offset, clamped.
  always_comb begin
    offset     = sat ? {1'b1, {(CW+1){1'b0}}} : {1'b0, qr};
    coord_base = (phase == PH_Y) ? (CW+3)'(origin_y) : (CW+3)'(origin_x);
    coord_neg  = (phase == PH_Y) ? dir_y[CW-1] : dir_x[CW-1];
    if (coord_neg) begin
      coord_sum = coord_base - $signed({1'b0, offset});
    end else begin
      coord_sum = coord_base + $signed({1'b0, offset});
    end
    if (coord_sum > COORD_MAX) begin
      coord_val = {1'b0, {(CW-1){1'b1}}};
    end else if (coord_sum < COORD_MIN) begin
      coord_val = {1'b1, {(CW-1){1'b0}}};
    end else begin
      coord_val = coord_sum[CW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (wall_valid) state_next = ST_CROSS;
      end
      ST_CROSS: begin
        if (cnt == CROSS_LAST) state_next = ST_ORIENT;
      end
      ST_ORIENT: state_next = ST_TEST;
      ST_TEST: begin
        state_next = hit_ok ? ST_PROD : ST_DONE;
      end
      ST_PROD: begin
        if (cnt == PROD_LAST) state_next = ST_SAT;
      end
      ST_SAT: begin
        state_next = sat_now ? ST_STORE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == div_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        case (phase)
          PH_DIST: state_next = nearer ? ST_PROD : ST_DONE;
          PH_X:    state_next = ST_PROD;
          default: state_next = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and shared multiplier operands.
  always_comb begin
    wall_stall = (state != ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_CROSS: begin
        case (cnt)
          CNTW'(0): begin mul_a = MW'(e_x);   mul_b = MW'(w_y);   end
          CNTW'(1): begin mul_a = MW'(e_y);   mul_b = MW'(w_x);   end
          CNTW'(2): begin mul_a = MW'(dir_x); mul_b = MW'(w_y);   end
          CNTW'(3): begin mul_a = MW'(dir_y); mul_b = MW'(w_x);   end
          CNTW'(4): begin mul_a = MW'(e_x);   mul_b = MW'(dir_y); end
          CNTW'(5): begin mul_a = MW'(e_y);   mul_b = MW'(dir_x); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_PROD: begin
        mul_b = $signed(MW'(factor));
        if (cnt == '0) begin
          mul_a = $signed(MW'(n1mag[LOW-1:0]));
        end else begin
          mul_a = $signed(MW'(n1mag[MAGW-1:LOW]));
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CNTW'(1);
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      dir_x      <= CW'(256);
      dir_y      <= '0;
      dir_length <= CW'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_DIR_X:      dir_x      <= cfg_data;
        REG_DIR_Y:      dir_y      <= cfg_data;
        REG_DIR_LENGTH: dir_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stored nearest hit: cleared by a new ray, replaced as each quotient is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_hit         <= 1'b0;
      nearest_distance <= '0;
      nearest_x        <= '0;
      nearest_y        <= '0;
    end else if (state == ST_IDLE) begin
      if (wall_valid && wall.new_ray) begin
        have_hit         <= 1'b0;
        nearest_distance <= '0;
        nearest_x        <= '0;
        nearest_y        <= '0;
      end
    end else if (state == ST_STORE) begin
      case (phase)
        PH_DIST: begin
          if (nearer) begin
            have_hit         <= 1'b1;
            nearest_distance <= dist_val;
          end
        end
        PH_X:    nearest_x <= coord_val;
        default: nearest_y <= coord_val;
      endcase
    end
  end

  // Working datapath of one wall.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DIST;
      updated <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (wall_valid) begin
            e_x     <= EW'(wall.wall_start_x) - EW'(origin_x);
            e_y     <= EW'(wall.wall_start_y) - EW'(origin_y);
            w_x     <= wall.wall_vec_x;
            w_y     <= wall.wall_vec_y;
            phase   <= PH_DIST;
            updated <= 1'b0;
          end
        end
        ST_CROSS: begin
          // Odd steps hold the first term, even steps close one cross product.
          if (cnt[0]) begin
            first <= prod;
          end else if (cnt != '0) begin
            case (cnt[2:1])
              2'd1:    n1  <= XW'(first - prod);
              2'd2:    den <= XW'(first - prod);
              default: n2  <= XW'(first - prod);
            endcase
          end
        end
        ST_ORIENT: begin
          // Make the denominator positive so both ratios are tested by sign alone.
          if (den[XW-1]) begin
            n1  <= -n1;
            n2  <= -n2;
            den <= -den;
          end
        end
        ST_TEST: begin
          n1mag  <= n1[MAGW-1:0];
          denmag <= den[MAGW-1:0];
        end
        ST_PROD: begin
          if (cnt == CNTW'(1)) begin
            acc <= PW'($unsigned(prod));
          end else if (cnt == PROD_LAST) begin
            acc <= acc + (PW'($unsigned(prod)) << LOW);
          end
        end
        ST_SAT: begin
          sat <= sat_now;
          rem <= rem_init[MAGW-1:0];
          qr  <= qr_init;
        end
        ST_DIV: begin
          rem <= r2_ge ? r2_diff[MAGW-1:0] : r2[MAGW-1:0];
          qr  <= {qr[CW-1:0], r2_ge};
        end
        ST_STORE: begin
          case (phase)
            PH_DIST: phase <= PH_X;
            PH_X:    phase <= PH_Y;
            default: updated <= 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded once the wall is finished, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid        <= 1'b1;
      result.updated      <= updated;
      result.hit_valid    <= have_hit;
      result.hit_x        <= nearest_x;
      result.hit_y        <= nearest_y;
      result.hit_distance <= nearest_distance;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // A new result word only comes out of the finishing state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result word raised outside the finishing state");

  // Without a stored hit the point and distance read as zero.
  a_empty_hit_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit_valid |->
      result.hit_x == '0 && result.hit_y == '0 && result.hit_distance == '0)
    else $error("empty hit carries a nonzero point or distance");

  // A wall that became the nearest hit leaves a stored hit behind.
  a_updated_has_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.updated |-> result.hit_valid)
    else $error("updated word without a stored hit");

  // The divider remainder stays below the divisor throughout the division.
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < denmag)
    else $error("divider remainder not below divisor");

endmodule

>>> tb/sv/ray_segment_nearest_hit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ray_segment_nearest_hit: a directed table and random wall words.
// Results are checked in order against the typed table word or a local nearest-hit predictor; depends on rsnh_pkg.
module ray_segment_nearest_hit_tb;
  import rsnh_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NUM_DIRECTED = 18;
  localparam int WALLS_PER_SETTING = 234;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 110;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [127:0] OFFSET_CAP = 128'(1) << (CW + 1);

  // One row of the directed table: the wall word and, where typed, the result word.
  typedef struct packed {
    wall_t   w;
    logic    typed;
    result_t want;
  } wall_case_t;

  // Reset config: origin (0,0), direction (1,0), length 1. Ray runs along +x.
  localparam wall_case_t DIRECTED [NUM_DIRECTED] = '{
    // Hit mid-segment at x = 10.
    '{'{1'b1, 24'sd2560, -24'sd256, 24'sd0, 24'sd512}, 1'b1,
      '{1'b1, 1'b1, 24'sd2560, 24'sd0, 24'd2560}},
    // Parallel wall.
    '{'{1'b0, 24'sd0, 24'sd256, 24'sd512, 24'sd0}, 1'b1,
      '{1'b0, 1'b1, 24'sd2560, 24'sd0, 24'd2560}},
    // Wall behind the origin.
    '{'{1'b0, -24'sd2560, -24'sd256, 24'sd0, 24'sd512}, 1'b1,
      '{1'b0, 1'b1, 24'sd2560, 24'sd0, 24'd2560}},
    // Nearer hit exactly at the segment start.
    '{'{1'b0, 24'sd1280, 24'sd0, 24'sd0, 24'sd256}, 1'b1,
      '{1'b1, 1'b1, 24'sd1280, 24'sd0, 24'd1280}},
    // Nearer hit exactly at the segment end.
    '{'{1'b0, 24'sd512, -24'sd256, 24'sd0, 24'sd256}, 1'b1,
      '{1'b1, 1'b1, 24'sd512, 24'sd0, 24'd512}},
    // Same distance does not replace.
    '{'{1'b0, 24'sd512, -24'sd512, 24'sd0, 24'sd1024}, 1'b1,
      '{1'b0, 1'b1, 24'sd512, 24'sd0, 24'd512}},
    // Past the segment end.
    '{'{1'b0, 24'sd256, -24'sd768, 24'sd0, 24'sd512}, 1'b1,
      '{1'b0, 1'b1, 24'sd512, 24'sd0, 24'd512}},
    // Before the segment start.
    '{'{1'b0, 24'sd256, 24'sd256, 24'sd0, 24'sd512}, 1'b1,
      '{1'b0, 1'b1, 24'sd512, 24'sd0, 24'd512}},
    // Hit at the origin itself.
    '{'{1'b0, 24'sd0, -24'sd256, 24'sd0, 24'sd512}, 1'b1,
      '{1'b1, 1'b1, 24'sd0, 24'sd0, 24'd0}},
    // New ray with a zero wall vector: cleared, no hit.
    '{'{1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1,
      '{1'b0, 1'b0, 24'sd0, 24'sd0, 24'd0}},
    // Negative cross product, first hit of the ray.
    '{'{1'b0, 24'sd768, 24'sd256, 24'sd0, -24'sd512}, 1'b1,
      '{1'b1, 1'b1, 24'sd768, 24'sd0, 24'd768}},
    // Field extremes.
    '{'{1'b1, CMAX, CMIN, CMIN, CMAX}, 1'b0, '0},
    '{'{1'b0, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
    '{'{1'b0, CMAX, 24'sd0, 24'sd0, CMIN}, 1'b0, '0},
    '{'{1'b1, 24'sd2560, CMIN, 24'sd0, CMAX}, 1'b0, '0},
    '{'{1'b0, CMIN, CMIN, CMIN, CMIN}, 1'b0, '0},
    '{'{1'b1, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0},
    '{'{1'b0, CMAX, -24'sd256, 24'sd0, 24'sd512}, 1'b0, '0}
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            wall_valid = 1'b0;
  logic            wall_stall;
  wall_t           wall = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  result_t         result;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IDXW-1:0] cfg_index = REG_ORIGIN_X;
  logic [CW-1:0]   cfg_data = '0;

  // Local copy of the ray registers, at their reset values.
  logic signed [CW-1:0] ray_ox = '0;
  logic signed [CW-1:0] ray_oy = '0;
  logic signed [CW-1:0] ray_dx = 24'sd256;
  logic signed [CW-1:0] ray_dy = '0;
  logic        [CW-1:0] ray_len = 24'd256;

  // Local copy of the stored nearest hit.
  logic                 near_valid = 1'b0;
  logic        [CW-1:0] near_dist = '0;
  logic signed [CW-1:0] near_x = '0;
  logic signed [CW-1:0] near_y = '0;

  result_t     hits_due[$];
  int          error_count = 0;
  int          walls_sent = 0;
  int          cycle_count = 0;
  int unsigned snd_idle_pct = 24;
  int unsigned rcv_idle_pct = 55;
  logic        hold_results = 1'b0;

  ray_segment_nearest_hit u_top (
    .clk          (clk),
    .rst          (rst),
    .wall_valid   (wall_valid),
    .wall_stall   (wall_stall),
    .wall         (wall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // One axis of the hit point: origin plus |d.c| * N1 / D toward the sign of d.c, clamped.
  function automatic logic signed [CW-1:0] hit_axis(input longint o, input longint dc,
                                                     input logic [127:0] n1w,
                                                     input longint den);
    logic [127:0] offset;
    longint       v;
    offset = 128'(dc < 0 ? -dc : dc) * n1w / 128'(den);
    if (offset > OFFSET_CAP) offset = OFFSET_CAP;
    v = dc < 0 ? o - longint'(offset) : o + longint'(offset);
    if (v > longint'(CMAX)) v = longint'(CMAX);
    if (v < longint'(CMIN)) v = longint'(CMIN);
    return CW'(v);
  endfunction

  // Updates the stored nearest hit with one wall and returns the result word it must give.
  function automatic result_t nearest_after_wall(input wall_t w);
    longint       ex, ey, wx, wy, dx, dy, den, n1, n2;
    logic [127:0] n1w, q;
    logic [CW-1:0] wall_dist;
    result_t      r;
    r = '0;
    dx = longint'(ray_dx);
    dy = longint'(ray_dy);
    wx = longint'(w.wall_vec_x);
    wy = longint'(w.wall_vec_y);
    ex = longint'(w.wall_start_x) - longint'(ray_ox);
    ey = longint'(w.wall_start_y) - longint'(ray_oy);
    if (w.new_ray) begin
      near_valid = 1'b0;
      near_dist = '0;
      near_x = '0;
      near_y = '0;
    end
    den = dx * wy - dy * wx;
    n1 = ex * wy - ey * wx;
    n2 = ex * dy - ey * dx;
    // A zero cross product is parallel or has no direction: never a hit.
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        n1 = -n1;
        n2 = -n2;
      end
      if (n1 >= 0 && n2 >= 0 && n2 <= den) begin
        n1w = 128'(n1);
        q = n1w * 128'(ray_len) / 128'(den);
        wall_dist = (q > 128'({CW{1'b1}})) ? {CW{1'b1}} : q[CW-1:0];
        if (!near_valid || wall_dist < near_dist) begin
          near_dist = wall_dist;
          near_x = hit_axis(longint'(ray_ox), dx, n1w, den);
          near_y = hit_axis(longint'(ray_oy), dy, n1w, den);
          near_valid = 1'b1;
          r.updated = 1'b1;
        end
      end
    end
    r.hit_valid = near_valid;
    r.hit_x = near_x;
    r.hit_y = near_y;
    r.hit_distance = near_dist;
    return r;
  endfunction

  // Offers one wall word after a random gap and records its expected result word.
  task automatic send_wall(input wall_t w, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      wall_valid <= 1'b0;
      @(posedge clk);
    end
    wall <= w;
    wall_valid <= 1'b1;
    do @(posedge clk); while (wall_stall);
    predicted = nearest_after_wall(w);
    hits_due.push_back(typed ? want : predicted);
    walls_sent++;
  endtask

  // Writes all five ray registers, keeping the write valid up between words.
  task automatic load_ray(input logic [CW-1:0] ox, oy, dx, dy, len);
    logic [IDXW-1:0] idx [5];
    logic [CW-1:0]   vals [5];
    idx = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_DIR_X, REG_DIR_Y, REG_DIR_LENGTH};
    vals = '{ox, oy, dx, dy, len};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    ray_ox = ox;
    ray_oy = oy;
    ray_dx = dx;
    ray_dy = dy;
    ray_len = len;
  endtask

  // Result checker and random receiver stall.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (hits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %p", result));
        end else begin
          want = hits_due.pop_front();
          if (result.updated !== want.updated)
            report_mismatch($sformatf("updated: got %b, want %b", result.updated,
                                      want.updated));
          if (result.hit_valid !== want.hit_valid)
            report_mismatch($sformatf("hit_valid: got %b, want %b", result.hit_valid,
                                      want.hit_valid));
          if (result.hit_x !== want.hit_x)
            report_mismatch($sformatf("hit_x: got %0d, want %0d", result.hit_x,
                                      want.hit_x));
          if (result.hit_y !== want.hit_y)
            report_mismatch($sformatf("hit_y: got %0d, want %0d", result.hit_y,
                                      want.hit_y));
          if (result.hit_distance !== want.hit_distance)
            report_mismatch($sformatf("hit_distance: got %0d, want %0d",
                                      result.hit_distance, want.hit_distance));
        end
      end
      result_stall <= hold_results || ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Long receiver hold-off while walls keep coming, so the block backs up.
  initial begin : receiver_hold
    wait (walls_sent >= 300);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ray_segment_nearest_hit_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    wall_t    item;
    longint   k, f, vx, vy, px, py;
    int unsigned sel;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset ray.
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_wall(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].want);

    // Random walls under several ray settings; the stored hit carries across writes.
    for (int setting = 0; setting < 6; setting++) begin
      wall_valid <= 1'b0;
      wait (hits_due.size() == 0);
      case (setting)
        0: load_ray(24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'd362);
        1: load_ray(CMAX, CMIN, CMIN, CMAX, {CW{1'b1}});
        2: load_ray(CW'($urandom()), CW'($urandom()), 24'sd0, 24'sd0, 24'd0);
        3: load_ray(CMIN, CMAX, CMAX, CMIN, 24'd0);
        4: load_ray(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()),
                    CW'($urandom()));
        default: load_ray(CW'(longint'($urandom_range(0, 8191)) - 4096),
                          CW'(longint'($urandom_range(0, 8191)) - 4096),
                          CW'(longint'($urandom_range(0, 4095)) - 2048),
                          CW'(longint'($urandom_range(0, 4095)) - 2048),
                          CW'($urandom_range(0, 4096)));
      endcase
      if (setting == 2) begin
        snd_idle_pct <= 55;
        rcv_idle_pct <= 24;
      end else if (setting == 4) begin
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
      end
      for (int n = 0; n < WALLS_PER_SETTING; n++) begin
        sel = $urandom_range(0, 9);
        item.new_ray = ($urandom_range(0, 7) == 0);
        if (sel < 6) begin
          // Aimed wall: passes near the point at T1 = k/256, crossed at T2 near f/256.
          vx = longint'($urandom_range(0, 8191)) - 4096;
          vy = longint'($urandom_range(0, 8191)) - 4096;
          k = $urandom_range(0, 4096);
          f = $urandom_range(0, 256);
          px = longint'(ray_ox) + (k * longint'(ray_dx)) / 256;
          py = longint'(ray_oy) + (k * longint'(ray_dy)) / 256;
          item.wall_start_x = CW'(px - (f * vx) / 256);
          item.wall_start_y = CW'(py - (f * vy) / 256);
          item.wall_vec_x = CW'(vx);
          item.wall_vec_y = CW'(vy);
        end else if (sel < 8) begin
          item.wall_start_x = CW'(longint'($urandom_range(0, 8191)) - 4096);
          item.wall_start_y = CW'(longint'($urandom_range(0, 8191)) - 4096);
          item.wall_vec_x = CW'(longint'($urandom_range(0, 8191)) - 4096);
          item.wall_vec_y = CW'(longint'($urandom_range(0, 8191)) - 4096);
        end else begin
          item.wall_start_x = CW'($urandom());
          item.wall_start_y = CW'($urandom());
          item.wall_vec_x = CW'($urandom());
          item.wall_vec_y = CW'($urandom());
        end
        send_wall(item, 1'b0, '0);
      end
    end

    // Drain, then let the pipeline settle before the verdict.
    wall_valid <= 1'b0;
    wait (hits_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("ray_segment_nearest_hit_tb: done, clean");
    else
      $display("ray_segment_nearest_hit_tb: done, errors");
    $finish;
  end

endmodule
